FILE: src/pbb_pkg.sv
// Shared constants, codes and types of the page bitmap blitter.
package pbb_pkg;

    // Default screen geometry.
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 64;

    // Widest frame store address over the allowed geometry (512 x 32 pages).
    localparam int ADDR_W_MAX = 14;

    // Configuration port.
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_POS_X  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_POS_Y  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_WIDTH  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_HEIGHT = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MIRROR = 3'd4;

    // Item commands.
    localparam logic CMD_DRAW = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // One frame store access, handed from the issue stage to the store.
    typedef struct packed {
        logic                  valid;
        logic                  write;     // 1: OR bits into the entry, 0: read it
        logic                  in_range;  // read address lies inside the store
        logic [ADDR_W_MAX-1:0] addr;
        logic [7:0]            bits;
    } t_op;

    // Read result returned by the store.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
    } t_rd;

endpackage

FILE: src/page_bitmap_blitter_unit.sv
// Top level of the page bitmap blitter: configuration, counters, issue stage and output.
//
//  channel   direction  handshake                     payload
//  input     in         i_in_valid / o_in_stall       i_cmd, i_pixel_byte, i_read_address
//  output    out        o_out_valid / i_out_stall     o_read_data
//  config    in         i_cfg_we                      i_cfg_index, i_cfg_data
//
// A draw item takes one issue phase per frame store page that it may touch, as the
// store has a single write port.
// A read item issues only once the result of the read before it has left the store
// and its own result will find the output register free.
// After reset the store is cleared one entry a cycle (1024 entries at the default
// geometry); no item is accepted until then, configuration writes are taken.
// A stalled result waits in the output register while further draw items go on.
module page_bitmap_blitter_unit #(
    parameter int SCREEN_WIDTH  = pbb_pkg::SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = pbb_pkg::SCREEN_HEIGHT
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pbb_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [pbb_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_cmd,
    input  logic [7:0]                      i_pixel_byte,
    input  logic [9:0]                      i_read_address,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [7:0]                      o_read_data
);

    localparam int PAGES       = SCREEN_HEIGHT / 8;
    localparam int STORE_BYTES = SCREEN_WIDTH * PAGES;
    localparam int AW          = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int PW          = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW          = $clog2(SCREEN_WIDTH);
    localparam int OPW         = pbb_pkg::ADDR_W_MAX;

    // Configuration registers.
    logic [15:0] r_pos_x;
    logic [15:0] r_pos_y;
    logic [7:0]  r_width;
    logic [7:0]  r_height;
    logic        r_mirror;

    // Bitmap counters.
    logic [7:0]  r_col;
    logic [4:0]  r_row;

    // Issue stage.
    logic               r_it_valid;
    logic               r_it_cmd;
    logic               r_it_active;
    logic [7:0]         r_it_byte;
    logic [9:0]         r_it_raddr;
    logic               r_it_rd_ok;
    logic               r_it_col_ok;
    logic [CW-1:0]      r_it_col_idx;
    logic signed [13:0] r_it_page;
    logic [2:0]         r_it_off;
    logic               r_phase;
    logic               r_rd_inflight;

    // Output register.
    logic       r_out_valid;
    logic [7:0] r_out_data;

    logic               accept;
    logic               draw_accept;
    logic               active;
    logic [7:0]         col_off;
    logic signed [16:0] col_sum;
    logic signed [13:0] page_sum;
    logic [5:0]         rows;
    logic [8:0]         col_next;
    logic [5:0]         row_next;
    logic               rd_issue_ok;
    logic               it_done;
    logic signed [14:0] op_page;
    logic               page_ok;
    logic [15:0]        shifted;
    logic [AW-1:0]      draw_addr;
    logic               clr_busy;
    pbb_pkg::t_op       op;
    pbb_pkg::t_rd       rd;

    // Screen place of the current bitmap byte, from the counters.
    always_comb begin
        active   = (r_width != 8'd0) && (r_height != 8'd0);
        col_off  = r_mirror ? (r_width - 8'd1 - r_col) : r_col;
        col_sum  = $signed({r_pos_x[15], r_pos_x}) + $signed({9'b0, col_off});
        page_sum = $signed({r_pos_y[15], r_pos_y[15:3]}) + $signed({9'b0, r_row});
        rows     = 6'(({1'b0, r_height} + 9'd7) >> 3);
        col_next = {1'b0, r_col} + 9'd1;
        row_next = {1'b0, r_row} + 6'd1;
    end

    // Item handshake: the issue stage takes a new item as the current one leaves.
    always_comb begin
        rd_issue_ok = !r_rd_inflight && (!r_out_valid || !i_out_stall);
        it_done     = r_it_valid && ((r_it_cmd == pbb_pkg::CMD_DRAW) ? r_phase : rd_issue_ok);
        o_in_stall  = clr_busy || (r_it_valid && !it_done);
        accept      = i_in_valid && !o_in_stall;
        draw_accept = accept && (i_cmd == pbb_pkg::CMD_DRAW) && active;
    end

    // Configuration registers and bitmap counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x  <= '0;
            r_pos_y  <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_mirror <= 1'b0;
            r_col    <= '0;
            r_row    <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                pbb_pkg::REG_POS_X:  r_pos_x  <= i_cfg_data;
                pbb_pkg::REG_POS_Y:  r_pos_y  <= i_cfg_data;
                pbb_pkg::REG_WIDTH:  r_width  <= i_cfg_data[7:0];
                pbb_pkg::REG_HEIGHT: r_height <= i_cfg_data[7:0];
                pbb_pkg::REG_MIRROR: r_mirror <= i_cfg_data[0];
                default: ;
            endcase
            if (i_cfg_index <= pbb_pkg::REG_MIRROR) begin
                r_col <= '0;
                r_row <= '0;
            end
        end else if (draw_accept) begin
            if (col_next >= {1'b0, r_width}) begin
                r_col <= '0;
                r_row <= (row_next >= rows) ? 5'd0 : row_next[4:0];
            end else begin
                r_col <= col_next[7:0];
            end
        end
    end

    // Issue stage control.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_it_valid    <= 1'b0;
            r_phase       <= 1'b0;
            r_rd_inflight <= 1'b0;
        end else begin
            if (accept) begin
                r_it_valid <= 1'b1;
                r_phase    <= 1'b0;
            end else begin
                if (it_done) begin
                    r_it_valid <= 1'b0;
                end
                if (r_it_valid && (r_it_cmd == pbb_pkg::CMD_DRAW) && !r_phase) begin
                    r_phase <= 1'b1;
                end
            end
            r_rd_inflight <= op.valid && !op.write;
        end
    end

    // Issue stage payload, captured with the item.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_it_cmd     <= i_cmd;
            r_it_active  <= active;
            r_it_byte    <= i_pixel_byte;
            r_it_raddr   <= i_read_address;
            r_it_rd_ok   <= {22'b0, i_read_address} < 32'(STORE_BYTES);
            r_it_col_ok  <= !col_sum[16] && (col_sum[15:0] < 16'(SCREEN_WIDTH));
            r_it_col_idx <= col_sum[CW-1:0];
            r_it_page    <= page_sum;
            r_it_off     <= r_pos_y[2:0];
        end
    end

    // Access for the current phase: the upper page first, then the page below.
    always_comb begin
        op_page   = $signed({r_it_page[13], r_it_page}) + $signed({14'b0, r_phase});
        page_ok   = !op_page[14] && (op_page[13:0] < 14'(PAGES));
        shifted   = {8'b0, r_it_byte} << r_it_off;
        draw_addr = AW'(op_page[PW-1:0]) * AW'(SCREEN_WIDTH) + AW'(r_it_col_idx);
        if (r_it_cmd == pbb_pkg::CMD_DRAW) begin
            op.valid    = r_it_valid && r_it_active && r_it_col_ok && page_ok
                          && (!r_phase || (r_it_off != 3'd0));
            op.write    = 1'b1;
            op.in_range = 1'b1;
            op.addr     = OPW'(draw_addr);
            op.bits     = r_phase ? shifted[15:8] : shifted[7:0];
        end else begin
            op.valid    = r_it_valid && rd_issue_ok;
            op.write    = 1'b0;
            op.in_range = r_it_rd_ok;
            op.addr     = OPW'(AW'(r_it_raddr));
            op.bits     = 8'h00;
        end
    end

    pbb_store #(
        .DEPTH (STORE_BYTES)
    ) u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_op    (op),
        .o_rd    (rd),
        .o_busy  (clr_busy)
    );

    // Output register holds a result until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (rd.valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (rd.valid) begin
            r_out_data <= rd.data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // A read result never lands on a result that is still waiting.
    a_out_not_overwritten: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd.valid |-> (!r_out_valid || !i_out_stall))
        else $error("read result overwrote a waiting result");

    // Every read result stems from a read issued in the previous cycle.
    a_rd_follows_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd.valid |-> $past(op.valid && !op.write))
        else $error("read result without a read access");

    // The column counter stays inside the bitmap.
    a_col_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col == 8'd0) || (r_col < r_width))
        else $error("bitmap column counter out of range");

    // The second phase of a draw item follows its first.
    a_phase_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_it_valid && r_phase) |->
            $past(r_it_valid && !r_phase && (r_it_cmd == pbb_pkg::CMD_DRAW)))
        else $error("draw item skipped its first phase");

endmodule

FILE: src/pbb_store.sv
// Frame store memory with read-modify-write stage, forwarding and reset clearing pass.
module pbb_store #(
    parameter int DEPTH = pbb_pkg::SCREEN_WIDTH * (pbb_pkg::SCREEN_HEIGHT / 8)
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  pbb_pkg::t_op i_op,
    output pbb_pkg::t_rd o_rd,
    output logic         o_busy
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [7:0]    mem [DEPTH];
    logic [7:0]    r_q;
    pbb_pkg::t_op  r_b;
    logic          r_b_valid;
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_addr;
    logic [7:0]    r_fw_data;
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;

    logic          b_write;
    logic [7:0]    old_data;
    logic [7:0]    new_data;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [7:0]    wr_data;

    // The entry written at the edge of this access's read is taken from the bypass.
    always_comb begin
        b_write  = r_b_valid && r_b.write;
        old_data = (r_fw_valid && (r_fw_addr == r_b.addr[AW-1:0])) ? r_fw_data : r_q;
        new_data = old_data | r_b.bits;
    end

    // Write port: the clearing pass owns it until the store is zero.
    always_comb begin
        wr_en   = r_clr_busy || b_write;
        wr_addr = r_clr_busy ? r_clr_addr : r_b.addr[AW-1:0];
        wr_data = r_clr_busy ? 8'h00 : new_data;
    end

    // Memory: one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (i_op.valid) begin
            r_q <= mem[i_op.addr[AW-1:0]];
        end
    end

    // Access stage and bypass register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
        end else begin
            r_b_valid  <= i_op.valid;
            r_fw_valid <= b_write;
        end
        r_b       <= i_op;
        r_fw_addr <= r_b.addr[AW-1:0];
        r_fw_data <= new_data;
    end

    // Clearing pass after reset, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end else begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    // Read results; addresses beyond the store read as zero.
    always_comb begin
        o_rd.valid = r_b_valid && !r_b.write;
        o_rd.data  = r_b.in_range ? old_data : 8'h00;
        o_busy     = r_clr_busy;
    end

    // No access reaches the store while it is being cleared.
    a_no_access_while_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_b_valid)
        else $error("store access during clearing pass");

    // The clearing pass ends only after the last entry.
    a_clear_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> ($past(r_clr_addr) == AW'(DEPTH - 1)))
        else $error("clearing pass ended early");

endmodule
